@@ sv/work_range_allocator_defines.svh @@
// assertion helpers for the work range allocator
`ifndef WORK_RANGE_ALLOCATOR_DEFINES_SVH
`define WORK_RANGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define WRA_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off while arst_n is low
`define WRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/wra_pkg.sv @@
`timescale 1ns / 1ps

package wra_pkg;

	localparam int MAX_SOURCES   = 16;
	localparam int MAX_INTERVALS = 8;
	localparam int IDX_W  = 32;
	localparam int SRC_W  = 4;
	localparam int NS_W   = $clog2(MAX_SOURCES + 1);
	localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
	localparam int SLOT_W = $clog2(MAX_INTERVALS);
	localparam int ADDR_W = SRC_W + SLOT_W;

	// configuration reset values
	localparam logic [IDX_W-1:0] CFG_FBS_RESET  = 32'd1000;
	localparam logic [NS_W-1:0]  CFG_NSRC_RESET = 5'd1;

	// command codes
	localparam logic [1:0] CMD_CONSUME = 2'd0;
	localparam logic [1:0] CMD_SETSIZE = 2'd1;
	localparam logic [1:0] CMD_RETURN  = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	// status codes
	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_NOTHING  = 3'd1;
	localparam logic [2:0] STATUS_CONFLICT = 3'd2;
	localparam logic [2:0] STATUS_BEYOND   = 3'd3;
	localparam logic [2:0] STATUS_OVERLAP  = 3'd4;
	localparam logic [2:0] STATUS_FULL     = 3'd5;

	typedef struct packed {
		logic [IDX_W-1:0] fbs;
		logic [NS_W-1:0]  nsrc;
	} wra_cfg_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [SRC_W-1:0] src;
		logic             pref;
		logic [IDX_W-1:0] req;
		logic [IDX_W-1:0] rf;
		logic [IDX_W-1:0] rl;
		logic [IDX_W-1:0] len;
	} wra_cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [SRC_W-1:0] out_source;
		logic [IDX_W-1:0] out_first;
		logic [IDX_W-1:0] out_last;
		logic             any_available;
		logic [IDX_W-1:0] items_left;
		logic [NS_W-1:0]  sources_done;
		logic [IDX_W-1:0] total_items;
		logic             total_known;
	} wra_result_t;

	typedef struct packed {
		logic [IDX_W-1:0] s;
		logic [IDX_W-1:0] e;
	} wra_intv_t;

endpackage

@@ sv/wra_ram.sv @@
`timescale 1ns / 1ps

module wra_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/wra_core.sv @@
`timescale 1ns / 1ps

module wra_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wra_pkg::wra_cfg_t    cfg,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  wra_pkg::wra_cmd_t    cmd,
	output logic                 res_valid,
	input  logic                 res_ready,
	output wra_pkg::wra_result_t res
);

	localparam int MS = wra_pkg::MAX_SOURCES;
	localparam int MI = wra_pkg::MAX_INTERVALS;
	localparam int IW = wra_pkg::IDX_W;
	localparam int SW = wra_pkg::SRC_W;
	localparam int NW = wra_pkg::NS_W;
	localparam int CW = wra_pkg::CNT_W;
	localparam int LW = wra_pkg::SLOT_W;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_DECODE, ST_PICK, ST_LOAD, ST_TAKE1, ST_TAKE2,
		ST_FIND, ST_INS1, ST_INS2, ST_WRITE, ST_SUM, ST_DONE
	} state_t;

	state_t               state_q;
	logic [SW-1:0]        sel_q;
	logic [SW-1:0]        anyp_q;
	logic                 found_any_q;
	logic [CW-1:0]        ptr_q;
	logic                 resp_q;
	logic [IW-1:0]        fbs_q;
	logic [NW-1:0]        active_q;
	wra_pkg::wra_cmd_t    cmd_q;
	logic [IW-1:0]        a_q, b_q;
	wra_pkg::wra_intv_t   iv_q [MI];
	logic [IW-1:0]        prev_e_q, cur_s_q, cur_e_q;
	logic                 ov_q, mp_q, ms_q;
	logic [IW-1:0]        diff_q, len_q, sz_q;
	wra_pkg::wra_result_t res_q;

	logic [IW-1:0]        size_q  [MS];
	logic                 known_q [MS];
	logic [IW-1:0]        free_q  [MS];
	logic [CW-1:0]        cnt_q   [MS];

	// per-source view at the one selected index
	logic [IW-1:0]      cur_size, cur_free;
	logic               cur_known;
	logic [CW-1:0]      cur_cnt;
	logic               last_sel, inactive, kin;
	logic [CW-1:0]      ptr_m1;
	wra_pkg::wra_intv_t iv_ptr;
	logic [NW-1:0]      restart_active;
	logic [IW:0]        left_sum, tot_sum;
	logic [IW-1:0]      tot_add;
	logic               found_any_next;
	logic [SW-1:0]      anyp_next;

	logic                        ram_we, ram_re;
	logic [wra_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
	wra_pkg::wra_intv_t          ram_wdata, ram_rdata;

	function automatic logic [NW-1:0] eff_sources(input logic [NW-1:0] n);
		logic [NW-1:0] r;
		r = n;
		if (n == '0) r = NW'(1);
		else if (n > NW'(MS)) r = NW'(MS);
		return r;
	endfunction

	assign cur_size  = size_q[sel_q];
	assign cur_free  = free_q[sel_q];
	assign cur_known = known_q[sel_q];
	assign cur_cnt   = cnt_q[sel_q];
	assign last_sel  = ({1'b0, sel_q} == active_q - NW'(1));
	assign inactive  = ({1'b0, cmd_q.src} >= active_q);
	assign kin       = ptr_q < cur_cnt;
	assign ptr_m1    = ptr_q - CW'(1);
	assign iv_ptr    = iv_q[ptr_q[LW-1:0]];
	assign restart_active = eff_sources(cfg.nsrc);

	// summary accumulation, saturating
	assign tot_add  = cur_known ? cur_size : fbs_q;
	assign left_sum = {1'b0, res_q.items_left} + {1'b0, cur_free};
	assign tot_sum  = {1'b0, res_q.total_items} + {1'b0, tot_add};

	assign found_any_next = found_any_q | (cur_cnt != '0);
	assign anyp_next      = found_any_q ? anyp_q : sel_q;

	// interval memory port control
	assign ram_we    = (state_q == ST_INIT) || (state_q == ST_WRITE);
	assign ram_waddr = (state_q == ST_INIT) ? {sel_q, LW'(0)} : {sel_q, ptr_q[LW-1:0]};
	assign ram_wdata = (state_q == ST_INIT) ? {{IW{1'b0}}, fbs_q} : iv_ptr;
	assign ram_re    = (state_q == ST_LOAD) && (ptr_q < CW'(MI));
	assign ram_raddr = {sel_q, ptr_q[LW-1:0]};

	wra_ram #(
		.WIDTH(2 * IW),
		.DEPTH(MS * MI)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sel_q       <= '0;
			ptr_q       <= '0;
			found_any_q <= 1'b0;
			resp_q      <= 1'b0;
			fbs_q       <= wra_pkg::CFG_FBS_RESET;
			active_q    <= wra_pkg::CFG_NSRC_RESET;
			for (int s = 0; s < MS; s++) begin
				size_q[s]  <= '0;
				known_q[s] <= 1'b0;
				if (NW'(s) < wra_pkg::CFG_NSRC_RESET) begin
					cnt_q[s]  <= CW'(1);
					free_q[s] <= wra_pkg::CFG_FBS_RESET;
				end else begin
					cnt_q[s]  <= '0;
					free_q[s] <= '0;
				end
			end
		end else begin
			case (state_q)
				// write the first block of every source
				ST_INIT: begin
					if (sel_q == SW'(MS - 1)) begin
						sel_q  <= '0;
						resp_q <= 1'b0;
						state_q <= resp_q ? ST_SUM : ST_IDLE;
					end else begin
						sel_q <= sel_q + SW'(1);
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						sel_q <= cmd.src;
						res_q <= '0;
						res_q.total_known <= 1'b1;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (cmd_q.cmd)
						wra_pkg::CMD_CONSUME: begin
							if (cmd_q.pref && !inactive && cur_cnt != '0) begin
								ptr_q   <= '0;
								state_q <= ST_LOAD;
							end else begin
								sel_q       <= '0;
								found_any_q <= 1'b0;
								state_q     <= ST_PICK;
							end
						end
						wra_pkg::CMD_SETSIZE: begin
							if (inactive) begin
								res_q.status <= wra_pkg::STATUS_BEYOND;
								sel_q <= '0;
								state_q <= ST_SUM;
							end else if (cur_known) begin
								if (cur_size != cmd_q.len) res_q.status <= wra_pkg::STATUS_CONFLICT;
								sel_q <= '0;
								state_q <= ST_SUM;
							end else if (cmd_q.len > fbs_q) begin
								a_q <= fbs_q;
								b_q <= cmd_q.len;
								ptr_q <= '0;
								state_q <= ST_LOAD;
							end else begin
								known_q[sel_q] <= 1'b1;
								size_q[sel_q]  <= cmd_q.len;
								sel_q <= '0;
								state_q <= ST_SUM;
							end
						end
						wra_pkg::CMD_RETURN: begin
							if (inactive || ((!cur_known || cmd_q.rl > cur_size) &&
								!(cmd_q.rf == '0 && cmd_q.rl == fbs_q)) ||
								cmd_q.rf > cmd_q.rl) begin
								res_q.status <= wra_pkg::STATUS_BEYOND;
								sel_q <= '0;
								state_q <= ST_SUM;
							end else if (cmd_q.rf < cmd_q.rl) begin
								a_q <= cmd_q.rf;
								b_q <= cmd_q.rl;
								ptr_q <= '0;
								state_q <= ST_LOAD;
							end else begin
								sel_q <= '0;
								state_q <= ST_SUM;
							end
						end
						wra_pkg::CMD_RESTART: begin
							fbs_q    <= cfg.fbs;
							active_q <= restart_active;
							for (int s = 0; s < MS; s++) begin
								size_q[s]  <= '0;
								known_q[s] <= 1'b0;
								if (NW'(s) < restart_active && cfg.fbs != '0) begin
									cnt_q[s]  <= CW'(1);
									free_q[s] <= cfg.fbs;
								end else begin
									cnt_q[s]  <= '0;
									free_q[s] <= '0;
								end
							end
							resp_q  <= 1'b1;
							sel_q   <= '0;
							state_q <= ST_INIT;
						end
						default: begin
							sel_q <= '0;
							state_q <= ST_SUM;
						end
					endcase
				end
				// untouched source first, else first with work left
				ST_PICK: begin
					if (cur_cnt != '0 && (!cur_known || cur_size == cur_free)) begin
						ptr_q   <= '0;
						state_q <= ST_LOAD;
					end else begin
						found_any_q <= found_any_next;
						anyp_q      <= anyp_next;
						if (last_sel) begin
							if (found_any_next) begin
								sel_q   <= anyp_next;
								ptr_q   <= '0;
								state_q <= ST_LOAD;
							end else begin
								res_q.status <= wra_pkg::STATUS_NOTHING;
								sel_q   <= '0;
								state_q <= ST_SUM;
							end
						end else begin
							sel_q <= sel_q + SW'(1);
						end
					end
				end
				// copy the source's intervals into the work buffer
				ST_LOAD: begin
					if (ptr_q != '0) iv_q[ptr_m1[LW-1:0]] <= ram_rdata;
					if (ptr_q == CW'(MI)) begin
						ptr_q   <= '0;
						state_q <= (cmd_q.cmd == wra_pkg::CMD_CONSUME) ? ST_TAKE1 : ST_FIND;
					end else begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				ST_TAKE1: begin
					len_q <= iv_q[0].e - iv_q[0].s;
					sz_q  <= (iv_q[0].s == '0 || cmd_q.req == '0) ? fbs_q : cmd_q.req;
					state_q <= ST_TAKE2;
				end
				// hand out the front, whole interval or a piece of it
				ST_TAKE2: begin
					res_q.out_source <= sel_q;
					res_q.out_first  <= iv_q[0].s;
					if (len_q <= sz_q) begin
						res_q.out_last <= iv_q[0].e;
						for (int i = 0; i < MI - 1; i++) iv_q[i] <= iv_q[(i + 1) % MI];
						cnt_q[sel_q]  <= cur_cnt - CW'(1);
						free_q[sel_q] <= cur_free - len_q;
					end else begin
						res_q.out_last <= iv_q[0].s + sz_q;
						iv_q[0].s      <= iv_q[0].s + sz_q;
						free_q[sel_q]  <= cur_free - sz_q;
					end
					ptr_q   <= '0;
					state_q <= ST_WRITE;
				end
				// find the first interval ending after the new start
				ST_FIND: begin
					if (kin && iv_ptr.e <= a_q) begin
						prev_e_q <= iv_ptr.e;
						ptr_q    <= ptr_q + CW'(1);
					end else begin
						cur_s_q <= iv_ptr.s;
						cur_e_q <= iv_ptr.e;
						state_q <= ST_INS1;
					end
				end
				ST_INS1: begin
					ov_q   <= kin && (cur_s_q < b_q);
					ms_q   <= kin && (cur_s_q == b_q);
					mp_q   <= (ptr_q != '0) && (prev_e_q == a_q);
					diff_q <= b_q - a_q;
					state_q <= ST_INS2;
				end
				// merge with neighbors or open a new interval
				ST_INS2: begin
					if (ov_q) begin
						res_q.status <= wra_pkg::STATUS_OVERLAP;
						sel_q   <= '0;
						state_q <= ST_SUM;
					end else if (!mp_q && !ms_q && cur_cnt >= CW'(MI)) begin
						res_q.status <= wra_pkg::STATUS_FULL;
						sel_q   <= '0;
						state_q <= ST_SUM;
					end else begin
						for (int i = 0; i < MI; i++) begin
							if (mp_q && ms_q) begin
								if (CW'(i + 1) == ptr_q) iv_q[i].e <= cur_e_q;
								else if (CW'(i) >= ptr_q && i < MI - 1)
									iv_q[i] <= iv_q[(i + 1) % MI];
							end else if (mp_q) begin
								if (CW'(i + 1) == ptr_q) iv_q[i].e <= b_q;
							end else if (ms_q) begin
								if (CW'(i) == ptr_q) iv_q[i].s <= a_q;
							end else begin
								if (CW'(i) == ptr_q) begin
									iv_q[i].s <= a_q;
									iv_q[i].e <= b_q;
								end else if (CW'(i) > ptr_q) begin
									iv_q[i] <= iv_q[(i + MI - 1) % MI];
								end
							end
						end
						if (mp_q && ms_q) cnt_q[sel_q] <= cur_cnt - CW'(1);
						else if (!mp_q && !ms_q) cnt_q[sel_q] <= cur_cnt + CW'(1);
						free_q[sel_q] <= cur_free + diff_q;
						if (cmd_q.cmd == wra_pkg::CMD_SETSIZE) begin
							known_q[sel_q] <= 1'b1;
							size_q[sel_q]  <= cmd_q.len;
						end
						ptr_q   <= '0;
						state_q <= ST_WRITE;
					end
				end
				// store the work buffer back
				ST_WRITE: begin
					if (ptr_q == CW'(MI - 1)) begin
						sel_q   <= '0;
						state_q <= ST_SUM;
					end else begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				// summary figures over the sources in use
				ST_SUM: begin
					if (cur_cnt != '0) res_q.any_available <= 1'b1;
					res_q.items_left  <= left_sum[IW] ? {IW{1'b1}} : left_sum[IW-1:0];
					res_q.total_items <= tot_sum[IW] ? {IW{1'b1}} : tot_sum[IW-1:0];
					if (cur_known) begin
						if (cur_cnt == '0) res_q.sources_done <= res_q.sources_done + NW'(1);
					end else begin
						res_q.total_known <= 1'b0;
					end
					if (last_sel) state_q <= ST_DONE;
					else sel_q <= sel_q + SW'(1);
				end
				ST_DONE: begin
					if (res_ready) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/work_range_allocator.sv @@
`timescale 1ns / 1ps
// Work range allocator: hands out, takes back and tracks index ranges of up
// to 16 sources. Commands arrive as beats on the s_ group (kind in s_tuser),
// one result beat per command leaves on the m_ group (status in m_tuser).
// The cfg channel writes first_block_size (index 0) and num_sources (index 1);
// it is always ready, and new values take effect at the next restart.
// One command at a time passes a small sequencer that drives one shared set
// of compare/add logic and an interval memory with one write and one read
// port. Its steps are decode, source pick, memory load, front take or
// interval search plus merge, write back, a summary scan over the sources
// in use, and the result. A restart rewrites the first block of every
// source and then runs the summary scan.
// After reset the block writes the first block of every source into the
// interval memory with s_tready low, then holds source 0 with [0, 1000)
// until configured and restarted.
// Results sit in an output register; while it is full and m_tready is low,
// the next command may run but its result waits and s_tready stays low.

`include "work_range_allocator_defines.svh"

module work_range_allocator (
	input  logic         clk,
	input  logic         arst_n,
	// command beats
	input  logic         s_tvalid,
	output logic         s_tready,
	// source_index, has_preference, req_block_size, range_first, range_last,
	// source_length, zero fill
	input  logic [135:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	// result beats
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_source, out_first, out_last, any_available, items_left, sources_done,
	// total_items, total_known, zero fill
	output logic [143:0] m_tdata,
	// status
	output logic [2:0]   m_tuser,
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int IW = wra_pkg::IDX_W;
	localparam int SW = wra_pkg::SRC_W;
	localparam int NW = wra_pkg::NS_W;
	localparam logic [0:0] REG_FBS  = 1'b0;
	localparam logic [0:0] REG_NSRC = 1'b1;
	localparam int GRANT_W = SW + 2 * IW;

	logic [IW-1:0]        fbs_cfg_q;
	logic [NW-1:0]        nsrc_cfg_q;
	wra_pkg::wra_cfg_t    cfg;
	wra_pkg::wra_cmd_t    cmd;
	wra_pkg::wra_result_t core_res, out_q;
	logic                 core_res_valid, core_res_ready, out_valid_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbs_cfg_q  <= wra_pkg::CFG_FBS_RESET;
			nsrc_cfg_q <= wra_pkg::CFG_NSRC_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FBS:  fbs_cfg_q  <= cfg_data;
				REG_NSRC: nsrc_cfg_q <= cfg_data[NW-1:0];
				default:  fbs_cfg_q  <= fbs_cfg_q;
			endcase
		end
	end
	assign cfg.fbs  = fbs_cfg_q;
	assign cfg.nsrc = nsrc_cfg_q;

	// unpack the command beat
	assign cmd.cmd  = s_tuser;
	assign cmd.src  = s_tdata[3:0];
	assign cmd.pref = s_tdata[4];
	assign cmd.req  = s_tdata[36:5];
	assign cmd.rf   = s_tdata[68:37];
	assign cmd.rl   = s_tdata[100:69];
	assign cmd.len  = s_tdata[132:101];

	wra_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd_valid(s_tvalid),
		.cmd_ready(s_tready),
		.cmd      (cmd),
		.res_valid(core_res_valid),
		.res_ready(core_res_ready),
		.res      (core_res)
	);

	// output register
	assign core_res_ready = !out_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_valid && core_res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (core_res_valid && core_res_ready) out_q <= core_res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'b0, out_q.total_known, out_q.total_items, out_q.sources_done,
		out_q.items_left, out_q.any_available, out_q.out_last, out_q.out_first,
		out_q.out_source};

	`WRA_ASSERT_IMPLY(a_busy_while_result_waits, core_res_valid, !s_tready,
		"command taken while a result waits")
	`WRA_ASSERT_IMPLY(a_no_grant_on_failure, m_tvalid && m_tuser != wra_pkg::STATUS_OK,
		m_tdata[GRANT_W-1:0] == '0, "failed command carries a range")
	`WRA_ASSERT_NEXT(a_result_registered, core_res_valid && core_res_ready, m_tvalid,
		"finished result not registered")

endmodule
